// ===== src/bffba_pkg.sv =====
// ----------------------------------------------------------------------------
// bffba_pkg
// Shared types and constants for the first-fit block allocator.
// ----------------------------------------------------------------------------
package bffba_pkg;

    localparam int WORD_W     = 8;
    localparam int WORD_SHIFT = 3;
    localparam int CFG_W      = 7;
    localparam int FIRST_W    = 6;
    localparam int COUNT_W    = 7;
    localparam int START_W    = 6;

    localparam logic [CFG_W-1:0] ACTIVE_RESET = 7'd64;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_BAD      = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_MOD_RD,
        S_MOD_WR,
        S_DONE
    } state_t;

endpackage

// ===== src/bffba_if.sv =====
// ----------------------------------------------------------------------------
// bffba request / response interfaces
// Valid/ready channels for allocator requests and their responses.
// ----------------------------------------------------------------------------
interface alloc_req_if;
    logic                              valid;
    logic                              ready;
    bffba_pkg::cmd_t                   cmd;
    logic [bffba_pkg::FIRST_W-1:0]     first_block;
    logic [bffba_pkg::COUNT_W-1:0]     block_count;

    modport source (output valid, output cmd, output first_block, output block_count,
                    input ready);
    modport sink   (input valid, input cmd, input first_block, input block_count,
                    output ready);
endinterface

interface alloc_rsp_if;
    logic                              valid;
    logic                              ready;
    bffba_pkg::status_t                status;
    logic [bffba_pkg::START_W-1:0]     run_start;

    modport source (output valid, output status, output run_start, input ready);
    modport sink   (input valid, input status, input run_start, output ready);
endinterface

// ===== src/bffba_ram.sv =====
// ----------------------------------------------------------------------------
// bffba_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module bffba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic                                        re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/bitmap_first_fit_block_allocator.sv =====
// ----------------------------------------------------------------------------
// bitmap_first_fit_block_allocator
// First-fit contiguous block allocator over a one-bit-per-block map in RAM.
// ----------------------------------------------------------------------------
// One request at a time. The occupancy map sits in a RAM of 8-bit words; each
// word visit is a read state followed by an evaluate or write state. An
// allocate scans words from the first up to the word where a free run ends,
// then rewrites each word the run covers; a free rewrites each word it
// touches; a bad request goes straight to the result. The map is clear right
// after reset (per-word valid flags), no sweep. The next request is taken
// once the result is loaded into the output register.
module bitmap_first_fit_block_allocator #(
    parameter int NUM_BLOCKS = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [bffba_pkg::CFG_W-1:0]       cfg_wdata,
    alloc_req_if.sink                         req,
    alloc_rsp_if.source                       rsp
);

    localparam int WORDS = (NUM_BLOCKS + bffba_pkg::WORD_W - 1) / bffba_pkg::WORD_W;
    localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int KW    = $clog2(WORDS * bffba_pkg::WORD_W + 1);
    localparam int AW    = (KW > 8) ? KW : 8;
    localparam logic [AW-1:0] NB = AW'(NUM_BLOCKS);

    bffba_pkg::state_t  state_reg, state_next;
    logic [WAW-1:0]     word_reg, word_next;
    logic [AW-1:0]      run_reg, run_next;
    logic [AW-1:0]      count_reg, count_next;
    logic [AW-1:0]      lo_reg, lo_next;
    logic [AW-1:0]      hi_reg, hi_next;
    logic [AW-1:0]      start_reg, start_next;
    logic               set_reg, set_next;
    bffba_pkg::status_t status_reg, status_next;
    logic               rd_vld_reg, rd_vld_next;
    logic [WORDS-1:0]   vld_reg;
    logic [bffba_pkg::CFG_W-1:0] active_reg;

    logic                       out_valid_reg;
    bffba_pkg::status_t         out_status_reg;
    logic [bffba_pkg::START_W-1:0] out_start_reg;

    logic [AW-1:0] len;
    logic [AW-1:0] act;
    logic [AW-1:0] req_cnt;
    logic [AW-1:0] req_fst;
    logic          req_bad;
    logic          accept;
    logic          out_load;

    logic                        ram_we;
    logic                        ram_re;
    logic [WAW-1:0]              ram_raddr;
    logic [bffba_pkg::WORD_W-1:0] ram_wdata;
    logic [bffba_pkg::WORD_W-1:0] ram_rdata;
    logic [bffba_pkg::WORD_W-1:0] word_data;

    logic          scan_found;
    logic [AW-1:0] scan_end;
    logic [AW-1:0] scan_run;
    logic          scan_last;
    logic [bffba_pkg::WORD_W-1:0] mod_mask;
    logic          mod_last;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= bffba_pkg::ACTIVE_RESET;
        end
        else if (cfg_we)
        begin
            active_reg <= cfg_wdata;
        end
    end

    assign act     = AW'(active_reg);
    assign len     = (act > NB) ? NB : act;
    assign req_cnt = AW'(req.block_count);
    assign req_fst = AW'(req.first_block);

    always_comb
    begin
        req_bad = 1'b0;
        if (req_cnt == '0)
        begin
            req_bad = 1'b1;
        end
        else if (req.cmd == bffba_pkg::CMD_FREE)
        begin
            req_bad = (req_fst + req_cnt) > len;
        end
        else
        begin
            req_bad = req_cnt > len;
        end
    end

    assign req.ready = (state_reg == bffba_pkg::S_IDLE);
    assign accept    = req.valid && req.ready;
    assign out_load  = (state_reg == bffba_pkg::S_DONE) && (!out_valid_reg || rsp.ready);

    // map storage
    assign word_data = rd_vld_reg ? ram_rdata : '0;

    bffba_ram #(
        .WIDTH (bffba_pkg::WORD_W),
        .DEPTH (WORDS)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (word_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // run search across one word
    always_comb
    begin
        logic [AW-1:0] pos;
        logic [AW-1:0] run;
        logic          found;
        run   = run_reg;
        found = 1'b0;
        scan_end = '0;
        for (int j = 0; j < bffba_pkg::WORD_W; j++)
        begin
            pos = AW'({word_reg, 3'(j)});
            if (!found && (pos < len))
            begin
                if (word_data[j])
                begin
                    run = '0;
                end
                else
                begin
                    run = run + AW'(1);
                end
                if (run == count_reg)
                begin
                    found    = 1'b1;
                    scan_end = pos;
                end
            end
        end
        scan_found = found;
        scan_run   = run;
        scan_last  = ((AW'(word_reg) + AW'(1)) << bffba_pkg::WORD_SHIFT) >= len;
    end

    // run mask for the current word
    always_comb
    begin
        logic [AW-1:0] pos;
        for (int j = 0; j < bffba_pkg::WORD_W; j++)
        begin
            pos = AW'({word_reg, 3'(j)});
            mod_mask[j] = (pos >= lo_reg) && (pos <= hi_reg);
        end
        mod_last  = AW'(word_reg) == (hi_reg >> bffba_pkg::WORD_SHIFT);
        ram_wdata = set_reg ? (word_data | mod_mask) : (word_data & ~mod_mask);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bffba_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (req_bad)
                    begin
                        state_next = bffba_pkg::S_DONE;
                    end
                    else if (req.cmd == bffba_pkg::CMD_FREE)
                    begin
                        state_next = bffba_pkg::S_MOD_RD;
                    end
                    else
                    begin
                        state_next = bffba_pkg::S_SCAN_RD;
                    end
                end
            end
            bffba_pkg::S_SCAN_RD:  state_next = bffba_pkg::S_SCAN_CHK;
            bffba_pkg::S_SCAN_CHK:
            begin
                if (scan_found)
                begin
                    state_next = bffba_pkg::S_MOD_RD;
                end
                else if (scan_last)
                begin
                    state_next = bffba_pkg::S_DONE;
                end
                else
                begin
                    state_next = bffba_pkg::S_SCAN_RD;
                end
            end
            bffba_pkg::S_MOD_RD:   state_next = bffba_pkg::S_MOD_WR;
            bffba_pkg::S_MOD_WR:
            begin
                if (mod_last)
                begin
                    state_next = bffba_pkg::S_DONE;
                end
                else
                begin
                    state_next = bffba_pkg::S_MOD_RD;
                end
            end
            bffba_pkg::S_DONE:
            begin
                if (out_load)
                begin
                    state_next = bffba_pkg::S_IDLE;
                end
            end
            default:               state_next = bffba_pkg::S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        word_next   = word_reg;
        run_next    = run_reg;
        count_next  = count_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        start_next  = start_reg;
        set_next    = set_reg;
        status_next = status_reg;
        rd_vld_next = rd_vld_reg;
        ram_re      = 1'b0;
        ram_we      = 1'b0;
        ram_raddr   = word_reg;
        unique case (state_reg)
            bffba_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    start_next  = '0;
                    status_next = bffba_pkg::ST_DONE;
                    count_next  = req_cnt;
                    if (req_bad)
                    begin
                        status_next = bffba_pkg::ST_BAD;
                    end
                    else if (req.cmd == bffba_pkg::CMD_FREE)
                    begin
                        lo_next   = req_fst;
                        hi_next   = req_fst + req_cnt - AW'(1);
                        set_next  = 1'b0;
                        word_next = WAW'(req_fst >> bffba_pkg::WORD_SHIFT);
                    end
                    else
                    begin
                        run_next  = '0;
                        word_next = '0;
                    end
                end
            end
            bffba_pkg::S_SCAN_RD, bffba_pkg::S_MOD_RD:
            begin
                ram_re      = 1'b1;
                rd_vld_next = vld_reg[word_reg];
            end
            bffba_pkg::S_SCAN_CHK:
            begin
                if (scan_found)
                begin
                    lo_next    = scan_end + AW'(1) - count_reg;
                    hi_next    = scan_end;
                    start_next = scan_end + AW'(1) - count_reg;
                    set_next   = 1'b1;
                    word_next  = WAW'((scan_end + AW'(1) - count_reg) >> bffba_pkg::WORD_SHIFT);
                end
                else if (scan_last)
                begin
                    status_next = bffba_pkg::ST_NO_SPACE;
                    start_next  = '0;
                end
                else
                begin
                    run_next  = scan_run;
                    word_next = word_reg + WAW'(1);
                end
            end
            bffba_pkg::S_MOD_WR:
            begin
                ram_we = 1'b1;
                if (!mod_last)
                begin
                    word_next = word_reg + WAW'(1);
                end
            end
            bffba_pkg::S_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bffba_pkg::S_IDLE;
            vld_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_vld_reg <= rd_vld_next;
            if (ram_we)
            begin
                vld_reg[word_reg] <= 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg   <= word_next;
        run_reg    <= run_next;
        count_reg  <= count_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        start_reg  <= start_next;
        set_reg    <= set_next;
        status_reg <= status_next;
        if (out_load)
        begin
            out_status_reg <= status_reg;
            out_start_reg  <= start_reg[bffba_pkg::START_W-1:0];
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = out_status_reg;
    assign rsp.run_start = out_start_reg;

endmodule
